/* sv/qiw_pkg.sv */
package qiw_pkg;

   // field widths
   localparam int DT_W   = 32;   // Q8.24 depth step
   localparam int FRAC_W = 24;   // fraction bits of the depth step
   localparam int INT_W  = 8;    // integer bits of the depth step
   localparam int QW     = 61;   // Q.60 values in [0, 1]
   localparam int Q_FRAC = 60;
   localparam int ACC_W  = 64;   // signed weight accumulators
   localparam int OUT_W  = 32;   // Q2.30 weights

   // Horner form of exp(-f)
   localparam int EXP_TERMS = 20;
   localparam int TERM_LAT  = 5;

   localparam logic [QW-1:0] Q_ONE = {1'b1, {Q_FRAC{1'b0}}};

   // configuration registers
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_LIMIT = 1'd1;
   localparam logic [DT_W-1:0] SMALL_LIMIT_RST = 32'd8389;
   localparam logic [DT_W-1:0] LARGE_LIMIT_RST = 32'd838860800;

endpackage

/* sv/qiw_mul.sv */
module qiw_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic [AW-1:0] a,
   input  logic [BW-1:0] b,
   output logic [AW+BW-1:0] p
);
   localparam int NA  = (AW + 31) / 32;
   localparam int NB  = (BW + 31) / 32;
   localparam int AXW = 32 * NA;
   localparam int BXW = 32 * NB;
   localparam int PW  = 32 * (NA + NB);

   logic [AXW-1:0]   a_ext;
   logic [BXW-1:0]   b_ext;
   logic [63:0]      pp_ff [NA*NB];
   logic [PW-1:0]    sum_in;
   logic [AW+BW-1:0] p_ff;

   assign a_ext = AXW'(a);
   assign b_ext = BXW'(b);

   // 32x32 partial products first, then one summing stage
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i*NB+j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (PW'(pp_ff[i*NB+j]) << (32 * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sum_in[AW+BW-1:0];
      end
   end

   assign p = p_ff;

endmodule

/* sv/qiw_term.sv */
module qiw_term #(
   parameter int K = 20
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [qiw_pkg::FRAC_W-1:0] f,
   input  logic [qiw_pkg::QW-1:0]   p_i,
   output logic [qiw_pkg::QW-1:0]   p_o
);
   import qiw_pkg::*;

   localparam int L = $clog2(K);
   localparam int S = QW + L;

   logic [FRAC_W+QW-1:0] prod1;
   logic [QW-1:0]        x;
   logic [QW-1:0]        q;
   logic [QW-1:0]        p_ff;

   // x = floor(f * p / 2^24)
   qiw_mul #(.AW(FRAC_W), .BW(QW)) u_mul_fp (
      .clock(clock), .en(en), .a(f), .b(p_i), .p(prod1)
   );
   assign x = prod1[FRAC_W +: QW];

   generate
      if ((K & (K - 1)) == 0) begin : g_shift
         logic [QW-1:0] x_d1_ff;
         logic [QW-1:0] x_d2_ff;
         // match the latency of the reciprocal multiply
         always_ff @(posedge clock) begin
            if (en) begin
               x_d1_ff <= x;
               x_d2_ff <= x_d1_ff;
            end
         end
         assign q = x_d2_ff >> L;
      end else begin : g_recip
         // exact floor(x / K) for any x below 2^QW
         localparam logic [QW:0] M =
            (QW+1)'((((QW+8)'(1) << S) / (QW+8)'(K)) + (QW+8)'(1));
         logic [2*QW:0] prod2;
         qiw_mul #(.AW(QW), .BW(QW+1)) u_mul_rc (
            .clock(clock), .en(en), .a(x), .b(M), .p(prod2)
         );
         assign q = QW'(prod2 >> S);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= Q_ONE - q;
      end
   end

   assign p_o = p_ff;

endmodule

/* sv/quadratic_integration_weights_unit.sv */
// Quadratic integration weights: one depth step (unsigned Q8.24) in, three
// weights (unsigned Q2.30, saturated at 2.0) out. One transfer is taken in
// every cycle that the result side does not stall. The pipeline is the
// 20-step Horner chain for exp(-frac(dt)), five register stages a step (a
// 32x32 partial-product multiplier, then a second one or, for a power-of-two
// divisor, a shift), then nine stages that combine the integer-part table,
// the dt*e products and the Taylor forms. A stalled result freezes the whole
// pipeline, so nothing is lost or repeated. small_limit (index 0) and
// large_limit (index 1) are written through the csr port; the user must do
// so only while no transfer is in flight, as the block does not enforce it.
module quadratic_integration_weights_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [qiw_pkg::DT_W-1:0]      req_depth_step,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [qiw_pkg::OUT_W-1:0]     rsp_weight_zero,
   output logic [qiw_pkg::OUT_W-1:0]     rsp_weight_one,
   output logic [qiw_pkg::OUT_W-1:0]     rsp_weight_two,
   input  logic                          csr_write,
   input  logic [qiw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qiw_pkg::DT_W-1:0]      csr_data
);
   import qiw_pkg::*;

   localparam int B      = EXP_TERMS * TERM_LAT;
   localparam int DT_N   = B + 8;
   localparam int OUT_ST = B + 9;
   localparam int TAY_W  = 25;
   localparam int TAB_N  = 1 << INT_W;
   localparam int S3     = QW + 2;
   localparam logic [QW:0] M3 = (QW+1)'(((72'd1 << S3) / 72'd3) + 72'd1);
   localparam logic [ACC_W-1:0] THIRD = ACC_W'((ACC_W'(1) << Q_FRAC) / ACC_W'(3));
   localparam logic [ACC_W-1:0] HALF  = ACC_W'(1) << (Q_FRAC - 1);
   localparam logic [ACC_W-1:0] ONE_W = ACC_W'(Q_ONE);
   localparam logic [ACC_W-1:0] TWO_W = ACC_W'(Q_ONE) << 1;
   localparam logic [ACC_W-1:0] RND   = ACC_W'(1) << 29;
   localparam logic [OUT_W-1:0] SAT   = 32'h8000_0000;

   // exp(-n) by square-and-multiply from exp(-1)
   function automatic logic [QW-1:0] exp_int_value(input logic [INT_W-1:0] n);
      logic [127:0] r;
      logic [127:0] b;
      b = 128'(Q_ONE);
      for (int k = EXP_TERMS; k >= 1; k--) begin
         b = 128'(Q_ONE) - b / 128'(k);
      end
      r = 128'(Q_ONE);
      for (int i = 0; i < INT_W; i++) begin
         if (n[i]) begin
            r = (r * b) >> Q_FRAC;
         end
         b = (b * b) >> Q_FRAC;
      end
      return QW'(r);
   endfunction

   function automatic logic [OUT_W-1:0] to_q230(input logic [ACC_W-1:0] x);
      logic [ACC_W-1:0] r;
      r = (x + RND) >> 30;
      if (x[ACC_W-1] || x == '0) begin
         return '0;
      end
      if (r > ACC_W'(SAT)) begin
         return SAT;
      end
      return OUT_W'(r);
   endfunction

   logic                 adv;
   logic                 accept;
   logic [DT_W-1:0]      small_limit_ff;
   logic [DT_W-1:0]      large_limit_ff;
   logic                 v_ff [OUT_ST+1];
   logic [DT_W-1:0]      dt_ff [DT_N];
   logic [QW-1:0]        p_chain [EXP_TERMS+1];
   logic [QW-1:0]        exp_tab [TAB_N];

   // exponential path
   logic [QW-1:0]        ei_ff, ef_ff;
   logic [2*QW-1:0]      prod_e;
   logic [QW-1:0]        e;
   logic [QW-1:0]        e_d1_ff, e_d2_ff;
   logic [DT_W+QW-1:0]   prod_te;
   logic [ACC_W-1:0]     te;
   logic [DT_W+ACC_W-1:0] prod_t2e;
   logic [ACC_W-1:0]     t2e;
   logic [ACC_W-1:0]     w0_in, w1_raw_in, w1_in;
   logic [ACC_W-1:0]     xw0_a_ff, xw1_a_ff, xw0_b_ff, xw1_b_ff;
   logic [ACC_W-1:0]     xw0_ff, xw1_ff, xw2_ff;

   // Taylor path
   logic [TAY_W-1:0]     dta;
   logic [2*TAY_W-1:0]   prod_sq;
   logic [2*QW:0]        prod_q3;
   logic [QW-1:0]        q3;
   logic [QW-1:0]        f0;
   logic [TAY_W+QW-1:0]  prod_tw0;
   logic [QW-1:0]        tw0;
   logic [ACC_W-1:0]     f1_ff, f2_ff;
   logic [QW:0]          d2_ff;
   logic [3*TAY_W-1:0]   prod_cu;
   logic [QW+1:0]        d3;
   logic [QW+60:0]       prod_tw1;
   logic [QW+60:0]       prod_tw2;
   logic [QW-1:0]        tw1;
   logic [QW:0]          tw2;
   logic [QW-1:0]        tw0_a_ff, tw0_b_ff, tw0_c_ff, tw0_d_ff, tw1_a_ff;
   logic                 f1pos_a_ff, f1pos_b_ff, f1pos_c_ff, f2pos_a_ff, f2pos_b_ff;
   logic [ACC_W-1:0]     tay0_ff, tay1_ff, tay2_ff;
   logic                 small_ff, large_ff;

   // result stage
   logic [ACC_W-1:0]     sw0_in, sw1_in, sw2_in;
   logic [OUT_W-1:0]     wz_ff, wo_ff, wt_ff;

   assign adv       = !(v_ff[OUT_ST] && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         small_limit_ff <= SMALL_LIMIT_RST;
         large_limit_ff <= LARGE_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SMALL_LIMIT: small_limit_ff <= csr_data;
            CSR_LARGE_LIMIT: large_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // valid bits travel with the data; hold everything on a stalled result
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= OUT_ST; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i <= OUT_ST; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dt_ff[0] <= req_depth_step;
         for (int i = 1; i < DT_N; i++) begin
            dt_ff[i] <= dt_ff[i-1];
         end
      end
   end

   generate
      for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
         localparam logic [QW-1:0] EV = exp_int_value(INT_W'(gi));
         assign exp_tab[gi] = EV;
      end
   endgenerate

   // Horner chain for exp(-frac(dt))
   assign p_chain[0] = Q_ONE;
   generate
      for (genvar t = 0; t < EXP_TERMS; t++) begin : g_term
         qiw_term #(.K(EXP_TERMS - t)) u_term (
            .clock(clock),
            .en   (adv),
            .f    (dt_ff[TERM_LAT*t][FRAC_W-1:0]),
            .p_i  (p_chain[t]),
            .p_o  (p_chain[t+1])
         );
      end
   endgenerate

   // e = exp(-n) * exp(-f), then dt*e and dt^2*e
   qiw_mul #(.AW(QW), .BW(QW)) u_mul_e (
      .clock(clock), .en(adv), .a(ei_ff), .b(ef_ff), .p(prod_e)
   );
   assign e = QW'(prod_e >> Q_FRAC);

   qiw_mul #(.AW(DT_W), .BW(QW)) u_mul_te (
      .clock(clock), .en(adv), .a(dt_ff[B+3]), .b(e), .p(prod_te)
   );
   assign te = ACC_W'(prod_te >> FRAC_W);

   qiw_mul #(.AW(DT_W), .BW(ACC_W)) u_mul_t2e (
      .clock(clock), .en(adv), .a(dt_ff[B+5]), .b(te), .p(prod_t2e)
   );
   assign t2e = ACC_W'(prod_t2e >> FRAC_W);

   assign w0_in     = ONE_W - ACC_W'(e_d2_ff);
   assign w1_raw_in = w0_in - te;
   assign w1_in     = w1_raw_in[ACC_W-1] ? '0 : w1_raw_in;

   // Taylor forms
   assign dta = dt_ff[B+1][TAY_W-1:0];
   assign f0  = Q_ONE - ({dta, 36'd0} >> 1);

   qiw_mul #(.AW(TAY_W), .BW(TAY_W)) u_mul_sq (
      .clock(clock), .en(adv), .a(dta), .b(dta), .p(prod_sq)
   );

   qiw_mul #(.AW(QW), .BW(QW+1)) u_mul_q3 (
      .clock(clock), .en(adv), .a({dta, 36'd0}), .b(M3), .p(prod_q3)
   );
   assign q3 = QW'(prod_q3 >> S3);

   qiw_mul #(.AW(TAY_W), .BW(QW)) u_mul_tw0 (
      .clock(clock), .en(adv), .a(dta), .b(f0), .p(prod_tw0)
   );
   assign tw0 = QW'(prod_tw0 >> FRAC_W);

   qiw_mul #(.AW(2*TAY_W), .BW(TAY_W)) u_mul_cu (
      .clock(clock), .en(adv), .a(prod_sq), .b(dt_ff[B+3][TAY_W-1:0]), .p(prod_cu)
   );
   assign d3 = (QW+2)'(prod_cu >> 12);

   qiw_mul #(.AW(QW+1), .BW(60)) u_mul_tw1 (
      .clock(clock), .en(adv), .a(d2_ff), .b(f1_ff[59:0]), .p(prod_tw1)
   );
   assign tw1 = QW'(prod_tw1 >> Q_FRAC);

   qiw_mul #(.AW(QW+2), .BW(59)) u_mul_tw2 (
      .clock(clock), .en(adv), .a(d3), .b(f2_ff[58:0]), .p(prod_tw2)
   );
   assign tw2 = (QW+1)'(prod_tw2 >> Q_FRAC);

   always_ff @(posedge clock) begin
      if (adv) begin
         // exponential path
         ei_ff    <= exp_tab[dt_ff[B][DT_W-1:FRAC_W]];
         ef_ff    <= p_chain[EXP_TERMS];
         e_d1_ff  <= e;
         e_d2_ff  <= e_d1_ff;
         xw0_a_ff <= w0_in;
         xw1_a_ff <= w1_in;
         xw0_b_ff <= xw0_a_ff;
         xw1_b_ff <= xw1_a_ff;
         xw0_ff   <= xw0_b_ff;
         xw1_ff   <= xw1_b_ff;
         xw2_ff   <= (xw1_b_ff << 1) - t2e;
         // Taylor path
         f1_ff    <= HALF - ACC_W'(q3);
         d2_ff    <= {prod_sq, 12'd0};
         tw0_a_ff <= tw0;
         f2_ff    <= THIRD - ACC_W'({dt_ff[B+4][TAY_W-1:0], 34'd0});
         f1pos_a_ff <= !f1_ff[ACC_W-1] && (f1_ff != '0);
         tw0_b_ff <= tw0_a_ff;
         f1pos_b_ff <= f1pos_a_ff;
         f2pos_a_ff <= !f2_ff[ACC_W-1] && (f2_ff != '0);
         tw0_c_ff <= tw0_b_ff;
         f1pos_c_ff <= f1pos_b_ff;
         f2pos_b_ff <= f2pos_a_ff;
         tw0_d_ff <= tw0_c_ff;
         tw1_a_ff <= tw1;
         if (dt_ff[B+7][DT_W-1:TAY_W] == '0) begin
            tay0_ff <= ACC_W'(tw0_d_ff);
            tay1_ff <= f1pos_c_ff ? ACC_W'(tw1_a_ff) : '0;
            tay2_ff <= f2pos_b_ff ? ACC_W'(tw2) : '0;
         end else begin
            tay0_ff <= '0;
            tay1_ff <= '0;
            tay2_ff <= '0;
         end
         small_ff <= dt_ff[B+7] < small_limit_ff;
         large_ff <= dt_ff[B+7] > large_limit_ff;
         // result
         wz_ff <= to_q230(sw0_in);
         wo_ff <= to_q230(sw1_in);
         wt_ff <= to_q230(sw2_in);
      end
   end

   // small test wins over the large test
   always_comb begin
      if (small_ff) begin
         sw0_in = tay0_ff;
         sw1_in = tay1_ff;
         sw2_in = tay2_ff;
      end else if (large_ff) begin
         sw0_in = ONE_W;
         sw1_in = ONE_W;
         sw2_in = TWO_W;
      end else begin
         sw0_in = xw0_ff;
         sw1_in = xw1_ff;
         sw2_in = xw2_ff;
      end
   end

   assign rsp_valid       = v_ff[OUT_ST];
   assign rsp_weight_zero = wz_ff;
   assign rsp_weight_one  = wo_ff;
   assign rsp_weight_two  = wt_ff;

   a_weights_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight_zero <= SAT) && (rsp_weight_one <= SAT)
                    && (rsp_weight_two <= SAT))
      else $error("weight above 2.0");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> v_ff[0])
      else $error("accepted transfer not in first stage");

   a_pipe_advances: assert property (@(posedge clock) disable iff (reset)
      adv |=> (v_ff[OUT_ST] == $past(v_ff[OUT_ST-1])))
      else $error("result stage lost or repeated an item");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (v_ff[0] == $past(v_ff[0])) && $stable(dt_ff[0]))
      else $error("pipeline moved while stalled");

endmodule

/* tb/sv/tb_quadratic_integration_weights_unit.sv */
module tb_quadratic_integration_weights_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import qiw_pkg::*;

   localparam logic [63:0] UNIT_Q60 = 64'h1000_0000_0000_0000;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 140;

   typedef struct packed {
      logic [OUT_W-1:0] w0;
      logic [OUT_W-1:0] w1;
      logic [OUT_W-1:0] w2;
   } weight_set_type;

   class weight_scoreboard_type;
      weight_set_type awaited[$];
      logic [DT_W-1:0] taylor_below;
      logic [DT_W-1:0] const_above;
      int mismatches;
      int matched;

      function new();
         taylor_below = SMALL_LIMIT_RST;
         const_above  = LARGE_LIMIT_RST;
         mismatches   = 0;
         matched      = 0;
      endfunction

      function logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int s);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         p = p >> s;
         return p[63:0];
      endfunction

      // Horner chain for exp(-f), f in Q.24, result Q.60
      function logic [63:0] exp_fraction(logic [63:0] f);
         logic [63:0] p;
         p = UNIT_Q60;
         for (int k = EXP_TERMS; k >= 1; k--) begin
            p = UNIT_Q60 - mulsh(f, p, 24) / k;
         end
         return p;
      endfunction

      function logic [63:0] exp_whole(logic [INT_W-1:0] n);
         logic [63:0] r;
         logic [63:0] b;
         r = UNIT_Q60;
         b = exp_fraction(64'd1 << 24);
         for (int i = 0; i < INT_W; i++) begin
            if (n[i]) r = mulsh(r, b, 60);
            b = mulsh(b, b, 60);
         end
         return r;
      endfunction

      function logic [OUT_W-1:0] round_q230(longint x);
         logic [63:0] r;
         if (x <= 0) return '0;
         r = (64'(x) + (64'd1 << 29)) >> 30;
         if (r > (64'd1 << 31)) r = 64'd1 << 31;
         return r[OUT_W-1:0];
      endfunction

      function void set_limit(logic [CSR_IDX_W-1:0] idx, logic [DT_W-1:0] val);
         if (idx == CSR_SMALL_LIMIT) taylor_below = val;
         else if (idx == CSR_LARGE_LIMIT) const_above = val;
      endfunction

      function void note(logic [DT_W-1:0] dt);
         longint w0, w1, w2, f0, f1, f2;
         logic [63:0] d, d2, d3, e, te, t2e;
         weight_set_type ws;
         w0 = 0; w1 = 0; w2 = 0;
         if (dt < taylor_below) begin
            if (dt < (32'd1 << 25)) begin
               d  = {32'd0, dt} << 36;
               d2 = mulsh(d, d, 60);
               d3 = mulsh(d2, d, 60);
               f0 = longint'(UNIT_Q60) - longint'(d / 2);
               f1 = longint'(UNIT_Q60 / 2) - longint'(d / 3);
               f2 = longint'(UNIT_Q60 / 3) - longint'(d / 4);
               if (f0 > 0) w0 = longint'(mulsh(d, 64'(f0), 60));
               if (f1 > 0) w1 = longint'(mulsh(d2, 64'(f1), 60));
               if (f2 > 0) w2 = longint'(mulsh(d3, 64'(f2), 60));
            end
         end else if (dt > const_above) begin
            w0 = longint'(UNIT_Q60);
            w1 = longint'(UNIT_Q60);
            w2 = longint'(2 * UNIT_Q60);
         end else begin
            e   = mulsh(exp_whole(dt[31:24]), exp_fraction({40'd0, dt[23:0]}), 60);
            te  = mulsh({32'd0, dt}, e, 24);
            t2e = mulsh({32'd0, dt}, te, 24);
            w0 = longint'(UNIT_Q60) - longint'(e);
            w1 = w0 - longint'(te);
            if (w1 < 0) w1 = 0;
            w2 = 2 * w1 - longint'(t2e);
         end
         ws.w0 = round_q230(w0);
         ws.w1 = round_q230(w1);
         ws.w2 = round_q230(w2);
         awaited.push_back(ws);
      endfunction

      function void check(logic [OUT_W-1:0] a0, logic [OUT_W-1:0] a1,
                          logic [OUT_W-1:0] a2);
         weight_set_type ws;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h %h %h", a0, a1, a2);
            return;
         end
         ws = awaited.pop_front();
         if (ws.w0 !== a0 || ws.w1 !== a1 || ws.w2 !== a2) begin
            mismatches++;
            if (mismatches <= 10)
               $display("weight mismatch: exp %h %h %h got %h %h %h",
                        ws.w0, ws.w1, ws.w2, a0, a1, a2);
         end else begin
            matched++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [DT_W-1:0] req_depth_step;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_W-1:0] rsp_weight_zero;
   logic [OUT_W-1:0] rsp_weight_one;
   logic [OUT_W-1:0] rsp_weight_two;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DT_W-1:0] csr_data;

   weight_scoreboard_type sb = new();
   int cycles = 0;
   int sent = 0;
   int stall_left = 0;
   bit stall_quiet = 0;

   quadratic_integration_weights_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_depth_step(req_depth_step),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_weight_zero(rsp_weight_zero), .rsp_weight_one(rsp_weight_one),
      .rsp_weight_two(rsp_weight_two),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // score transfers on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note(req_depth_step);
         if (rsp_valid && !rsp_stall) sb.check(rsp_weight_zero, rsp_weight_one, rsp_weight_two);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
         $display("quadratic_integration_weights_unit verification failed");
         $finish;
      end
   end

   // result-side back pressure: mostly short stalls, some long, quiet stretches
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_quiet <= ~stall_quiet;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if (!stall_quiet && $urandom_range(0, 3) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 3);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_step(logic [DT_W-1:0] dt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_depth_step <= dt;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(logic [DT_W-1:0] lo, logic [DT_W-1:0] hi);
      csr_write <= 1;
      csr_index <= CSR_SMALL_LIMIT;
      csr_data <= lo;
      @(posedge clock);
      sb.set_limit(CSR_SMALL_LIMIT, lo);
      csr_index <= CSR_LARGE_LIMIT;
      csr_data <= hi;
      @(posedge clock);
      sb.set_limit(CSR_LARGE_LIMIT, hi);
      csr_write <= 0;
      @(posedge clock);
   endtask

   function logic [DT_W-1:0] random_step();
      int r;
      logic [DT_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 25) v = $urandom();
      else if (r < 45) v = $urandom_range(0, 32'h0000_4000);
      else if (r < 60) v = $urandom_range(0, 32'h0400_0000);
      else if (r < 70) v = sb.taylor_below + $urandom_range(0, 4) - 2;
      else if (r < 80) v = sb.const_above + $urandom_range(0, 4) - 2;
      else if (r < 90) v = (32'd1 << 25) + $urandom_range(0, 4) - 2;
      else v = {8'($urandom_range(0, 255)), 24'h0} | $urandom_range(0, 3);
      return v;
   endfunction

   logic [DT_W-1:0] directed[$] = '{32'd0, 32'd1, 32'd8388, 32'd8389, 32'd8390,
      32'h00FF_FFFF, 32'h0100_0000, 32'h0100_0001, 32'h01FF_FFFF, 32'h0200_0000,
      32'd838860799, 32'd838860800, 32'd838860801, 32'h7FFF_FFFF, 32'h8000_0000,
      32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0080_0000};

   logic [DT_W-1:0] lo_set[6] = '{SMALL_LIMIT_RST, 32'd0, 32'hFFFF_FFFF, 32'h0400_0000,
                                  32'h2000_0000, 32'h0001_0000};
   logic [DT_W-1:0] hi_set[6] = '{LARGE_LIMIT_RST, 32'd0, 32'hFFFF_FFFF, 32'h0800_0000,
                                  32'h1000_0000, 32'hFFFF_FFFF};

   initial begin
      reset = 1;
      req_valid = 0;
      req_depth_step = '0;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_step(directed[i]);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_limits(lo_set[ph], hi_set[ph]);
         foreach (directed[i]) if ((i % 3) == ph % 3) send_step(directed[i]);
         for (int n = 0; n < 82; n++) begin
            send_step(random_step());
            // hold off the sender until the pipeline is empty
            if (n == 45 && ph == 2) begin
               req_valid <= 0;
               while (sb.pending() != 0) @(posedge clock);
            end
         end
         drain();
      end
      if (sb.pending() != 0) sb.mismatches++;
      $display("%0d depth steps sent over 7 limit phases, %0d weight sets matched",
               sent, sb.matched);
      $display("limits covered: reset, zero, full scale, inverted and Taylor past 2.0");
      if (sb.mismatches == 0) begin
         $display("quadratic_integration_weights_unit verification clean");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("quadratic_integration_weights_unit verification failed");
      end
      $finish;
   end
endmodule

/* quadratic_integration_weights_unit.f */
sv/qiw_pkg.sv
sv/qiw_mul.sv
sv/qiw_term.sv
sv/quadratic_integration_weights_unit.sv
tb/sv/tb_quadratic_integration_weights_unit.sv
